[design/urde_pkg.sv]
// Shared types, constants and helpers for the radix digit emitter.
package urde_pkg;

  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 32;

  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [RADIX_W-1:0]    RADIX_RESET     = 5'd10;
  localparam logic [CFG_DATA_W-1:0] TABLE_LO_RESET  = 64'd3978425819141910832;
  localparam logic [CFG_DATA_W-1:0] TABLE_HI_RESET  = 64'd7378413942531504440;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_TABLE_LO = 2'd1,
    REG_TABLE_HI = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic               done;
    logic               nonzero;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] table_char(
    input logic [CFG_DATA_W-1:0] lo,
    input logic [CFG_DATA_W-1:0] hi,
    input logic [DIGIT_W-1:0]    digit
  );
    logic [5:0] sel;
    sel = {digit[2:0], 3'b000};
    if (digit[3]) begin
      return hi[sel +: CHAR_W];
    end
    return lo[sel +: CHAR_W];
  endfunction

endpackage

[design/urde_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, small radix divisor.
module urde_divider import urde_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output div_res_t              res
);

  localparam int BC_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] q_r,    q_nxt;
  logic [DIGIT_W-1:0]    rem_r,  rem_nxt;
  logic [BC_W-1:0]       bcnt_r, bcnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  nz_r,   nz_nxt;

  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               ge;

  assign trial = {rem_r, q_r[VALUE_BITS-1]};
  assign ge    = (trial >= divisor);
  assign diff  = trial - divisor;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    bcnt_nxt = bcnt_r;
    busy_nxt = busy_r;
    nz_nxt   = nz_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      bcnt_nxt = BC_W'(VALUE_BITS - 1);
      busy_nxt = 1'b1;
      nz_nxt   = 1'b0;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_BITS-2:0], ge};
      rem_nxt = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      nz_nxt  = nz_r | ge;
      if (bcnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bcnt_nxt = bcnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      nz_r   <= 1'b0;
      bcnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      nz_r   <= nz_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient    = q_r;
  assign res.done    = done_r;
  assign res.nonzero = nz_r;
  assign res.rem     = rem_r;

endmodule

[design/unsigned_radix_digit_emitter_unit.sv]
// Top level: unsigned value to radix digit characters, most significant first.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | in_valid / in_stall  | in_value
//  out     | out | out_valid / out_stall| out_character, out_char_valid,
//          |     |                      | out_digit_count, out_last
//  cfg     | in  | APB, pready tied hi  | radix @0x00, table low @0x08, high @0x10
//
// Each digit comes from one pass of the bit-serial divider (one quotient bit per
// cycle). The digits are then read back through the digit store read port, one
// beat each, most significant first. A disabled radix gives one beat.
// Synchronous active-low reset clears control state and restores the registers.
// The digit store needs no reset: every entry is written before it is read.
// A stall on out holds the output register and pauses the emit pass or the empty beat only.
module unsigned_radix_digit_emitter_unit import urde_pkg::*; #(
  parameter int MAX_RADIX  = DEF_MAX_RADIX,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [VALUE_BITS-1:0]            in_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [CHAR_W-1:0]                out_character,
  output logic                             out_char_valid,
  output logic [$clog2(MAX_DIGITS+1)-1:0]  out_digit_count,
  output logic                             out_last,
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]            cfg_paddr,
  input  logic [CFG_DATA_W-1:0]            cfg_pwdata,
  output logic [CFG_DATA_W-1:0]            cfg_prdata,
  output logic                             cfg_pready
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam logic [RADIX_W-1:0] RADIX_SAT = RADIX_W'(MAX_RADIX);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_DIGITS);

  // ---------------------------------------------------------------- config
  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] tbl_lo_r;
  logic [CFG_DATA_W-1:0] tbl_hi_r;
  logic                  cfg_we;
  reg_idx_t              cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // decode on the 8-byte register slot; low address bits ignored
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RESET;
      tbl_lo_r <= TABLE_LO_RESET;
      tbl_hi_r <= TABLE_HI_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RADIX: begin
          // saturate so a digit always lands inside the table
          radix_r <= (cfg_pwdata[RADIX_W-1:0] > RADIX_SAT) ? RADIX_SAT
                                                           : cfg_pwdata[RADIX_W-1:0];
        end
        REG_TABLE_LO: tbl_lo_r <= cfg_pwdata;
        REG_TABLE_HI: tbl_hi_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RADIX:    cfg_prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_r};
      REG_TABLE_LO: cfg_prdata = tbl_lo_r;
      REG_TABLE_HI: cfg_prdata = tbl_hi_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;     // digits written so far
  logic [IDX_W-1:0]   idx_r;     // store entry being emitted, counts down
  logic [DIGIT_W-1:0] rd_digit_r;

  logic out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic out_cv_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic out_last_r;

  logic                  slot_free;
  logic                  in_acc;
  logic                  radix_off;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  div_res_t              div_res;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  more_digits;

  logic mem_we;
  logic mem_re;
  logic load_empty;
  logic load_digit;

  assign slot_free   = !out_valid_r || !out_stall;
  assign in_acc      = in_valid && !in_stall;
  assign radix_off   = (radix_r <= RADIX_W'(1));
  assign cnt_inc     = cnt_r + 1'b1;
  assign more_digits = div_res.nonzero && (cnt_inc != CNT_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = radix_off ? S_EMPTY : S_DIV;
      end
      S_EMPTY: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (div_res.done && !more_digits) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) state_nxt = (idx_r == '0) ? S_IDLE : S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_dividend = div_quot;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    load_empty   = 1'b0;
    load_digit   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        div_dividend = in_value;
        div_start    = in_valid && !radix_off;
      end
      S_EMPTY: load_empty = slot_free;
      S_DIV: begin
        mem_we    = div_res.done;
        div_start = div_res.done && more_digits;
      end
      S_READ: mem_re = 1'b1;
      S_EMIT: load_digit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        cnt_r <= '0;
      end else if (mem_we) begin
        cnt_r <= cnt_inc;
        idx_r <= cnt_r[IDX_W-1:0];
      end else if (load_digit && (idx_r != '0)) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  urde_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix_r),
    .quotient (div_quot),
    .res      (div_res)
  );

  // digit store, least significant digit at entry 0
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (mem_we) digit_mem[cnt_r[IDX_W-1:0]] <= div_res.rem;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_digit_r <= digit_mem[idx_r];
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_empty || load_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      out_char_r <= '0;
      out_cv_r   <= 1'b0;
      out_cnt_r  <= '0;
      out_last_r <= 1'b1;
    end else if (load_digit) begin
      out_char_r <= table_char(tbl_lo_r, tbl_hi_r, rd_digit_r);
      out_cv_r   <= 1'b1;
      out_cnt_r  <= (idx_r == '0) ? cnt_r : '0;
      out_last_r <= (idx_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_character   = out_char_r;
  assign out_char_valid  = out_cv_r;
  assign out_digit_count = out_cnt_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------- checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_empty || load_digit) |-> slot_free)
    else $error("output register overwritten while a beat is pending");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("digit count beyond store depth");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && out_cv_r) |-> (out_cnt_r != '0))
    else $error("last digit beat without a digit count");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ($past(state_r) == S_READ || $past(state_r) == S_EMIT))
    else $error("emit without a store read");

endmodule

[test/tb.sv]
// Self-checking bench for the radix digit emitter: predicted digit beats against the result channel.
module tb;
  import urde_pkg::*;

  localparam int VBITS        = DEF_VALUE_BITS;
  localparam int CNT_W        = $clog2(DEF_MAX_DIGITS + 1);
  localparam int RANDOM_ITEMS = 260;
  // covers the slowest digit runs for every item, with plenty spare
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 1200;

  // one beat on the result channel
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              char_valid;
    logic [CNT_W-1:0]  digit_count;
    logic              last;
  } digit_beat_t;

  // Mirrors the register file and turns each accepted value into the digit beats it
  // should produce; result beats are checked against the oldest pending one.
  class digit_predictor;
    logic [RADIX_W-1:0]    radix;
    logic [CFG_DATA_W-1:0] chars_lo;
    logic [CFG_DATA_W-1:0] chars_hi;
    digit_beat_t           pending_beats[$];
    int unsigned           failures;

    function new();
      radix    = RADIX_RESET;
      chars_lo = TABLE_LO_RESET;
      chars_hi = TABLE_HI_RESET;
      failures = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        // anything above the table size saturates to the largest radix
        REG_RADIX: radix = (data[RADIX_W-1:0] > DEF_MAX_RADIX) ?
                           RADIX_W'(DEF_MAX_RADIX) : data[RADIX_W-1:0];
        REG_TABLE_LO: chars_lo = data;
        REG_TABLE_HI: chars_hi = data;
        default: ;
      endcase
    endfunction

    function void add_value(logic [VBITS-1:0] value);
      logic [DIGIT_W-1:0]      digits [DEF_MAX_DIGITS];
      logic [2*CFG_DATA_W-1:0] chars;
      logic [VBITS-1:0]        quo;
      digit_beat_t             beat;
      int                      n;
      // disabled radix: a single empty, closing beat
      if (radix <= 1) begin
        beat = '{character: '0, char_valid: 1'b0, digit_count: '0, last: 1'b1};
        pending_beats.push_back(beat);
        return;
      end
      chars = {chars_hi, chars_lo};
      quo   = value;
      n     = 0;
      // least significant digit first; zero still gives one digit
      do begin
        digits[n] = DIGIT_W'(quo % radix);
        quo       = quo / radix;
        n++;
      end while (quo != 0 && n < DEF_MAX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
        beat.character   = chars[digits[k] * CHAR_W +: CHAR_W];
        beat.char_valid  = 1'b1;
        beat.digit_count = (k == 0) ? CNT_W'(n) : '0;
        beat.last        = (k == 0);
        pending_beats.push_back(beat);
      end
    endfunction

    function void check_beat(digit_beat_t got);
      digit_beat_t want;
      if (pending_beats.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: char %h valid %b count %0d last %b",
                   got.character, got.char_valid, got.digit_count, got.last);
        return;
      end
      want = pending_beats.pop_front();
      if (got.character !== want.character || got.char_valid !== want.char_valid ||
          got.digit_count !== want.digit_count || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("beat mismatch: expected char %h valid %b count %0d last %b,",
                   want.character, want.char_valid, want.digit_count, want.last,
                   " got char %h valid %b count %0d last %b",
                   got.character, got.char_valid, got.digit_count, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [VBITS-1:0]      in_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_char_valid;
  logic [CNT_W-1:0]      out_digit_count;
  logic                  out_last;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  digit_predictor predictor = new();
  bit             idle_en  = 1'b1;  // sender gaps
  bit             stall_en = 1'b1;  // receiver stalls
  int unsigned    cycles   = 0;

  unsigned_radix_digit_emitter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_character   (out_character),
    .out_char_valid  (out_char_valid),
    .out_digit_count (out_digit_count),
    .out_last        (out_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, independent of out_valid.
  always @(posedge clk) begin
    out_stall <= stall_en && ($urandom_range(99) < 16);
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      predictor.check_beat(digit_beat_t'{out_character, out_char_valid,
                                         out_digit_count, out_last});
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one value, with random gaps in front, and hold it until the beat is taken.
  task automatic send_value(input logic [VBITS-1:0] value);
    while (idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    predictor.add_value(value);
  endtask

  // Sender holds off until every predicted beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (predictor.pending_beats.size() != 0) @(posedge clk);
  endtask

  // Setup then access; the next write may start straight after the access beat.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    predictor.write_reg(idx, data);
  endtask

  // Registers change only with the block idle.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] radix_data,
                              input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi);
    drain_results();
    write_reg(REG_RADIX, radix_data);
    write_reg(REG_TABLE_LO, lo);
    write_reg(REG_TABLE_HI, hi);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mix of full-range values, small ones, radix powers either side and all-ones.
  function automatic logic [VBITS-1:0] pick_value(input int unsigned r);
    longint unsigned p;
    int unsigned     k;
    case ($urandom_range(9))
      0, 1: return $urandom_range((r < 2) ? 100 : r * r * r);
      2: begin
        p = 1;
        k = $urandom_range(1, 31);
        while (k != 0 && p * r <= 64'hFFFF_FFFF) begin
          p = p * r;
          k--;
        end
        return $urandom_range(1) ? VBITS'(p) : VBITS'(p - 1);
      end
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_chars();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom);
    // now and then a table of one repeated character
    if ($urandom_range(7) == 0) return {8{ch}};
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] radix_data;
    int unsigned           sent;
    int unsigned           phase;
    int unsigned           count;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_value    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: decimal, lower-case table
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    // binary: widest output, 32 digits
    program_regs(64'd2, pick_chars(), pick_chars());
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1);
    send_value(32'h5555_5555);
    // hex with an upper-case table
    program_regs(64'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'hFFFF_FFFF);
    send_value(32'hDEAD_BEEF);
    send_value(32'hAAAA_AAAA);
    // radix 0 and 1 give the single empty beat
    program_regs(64'd0, pick_chars(), pick_chars());
    send_value(32'd7);
    send_value(32'hFFFF_FFFF);
    program_regs(64'd1, pick_chars(), pick_chars());
    send_value(32'd0);
    // over-range radix writes saturate to 16
    program_regs(64'd31, pick_chars(), pick_chars());
    send_value(32'hFEDC_BA98);
    send_value(32'h7654_3210);
    program_regs(64'd17, pick_chars(), pick_chars());
    send_value(32'h1234_5678);
    // every table entry the same character
    program_regs(64'd3, {8{8'h2A}}, {8{8'h2A}});
    send_value(32'hFFFF_FFFF);
    send_value(32'd0);

    // random phases: new settings each time, upper register bits randomised too
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      radix_data = {$urandom, $urandom};
      case ($urandom_range(19))
        0:       radix_data[RADIX_W-1:0] = RADIX_W'($urandom_range(1));
        1:       radix_data[RADIX_W-1:0] = RADIX_W'($urandom_range(31, 17));
        2, 3:    radix_data[RADIX_W-1:0] = RADIX_W'(2);
        default: radix_data[RADIX_W-1:0] = RADIX_W'($urandom_range(16, 2));
      endcase
      program_regs(radix_data, pick_chars(), pick_chars());
      // phase 1 runs flat out on both sides
      idle_en  = (phase != 1);
      stall_en = (phase != 1);
      count    = $urandom_range(24, 8);
      for (int i = 0; i < count; i++) begin
        send_value(pick_value(predictor.radix));
        sent++;
        if ((phase == 2 && i == count / 2) || $urandom_range(29) == 0)
          drain_results();
      end
      phase++;
    end

    drain_results();
    // extra beats after the last prediction show up as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predictor.failures == 0 && predictor.pending_beats.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
design/urde_pkg.sv
design/urde_divider.sv
design/unsigned_radix_digit_emitter_unit.sv
test/tb.sv
